@@ rtl/psc_pkg.sv @@
// Package for the pattern segmentation counter.
// Holds the transaction payload types, the controller state type and fixed constants.
// No dependencies.
`default_nettype none

package psc_pkg;

  localparam int SYM_W   = 8;
  localparam int COUNT_W = 64;

  localparam logic FUNC_PATTERN = 1'b0;
  localparam logic FUNC_DESIGN  = 1'b1;

  typedef struct packed {
    logic       func;
    logic [8:0] slot;
    logic [2:0] char_pos;
    logic [3:0] pattern_len;
    logic [7:0] symbol;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] ways;
    logic        possible;
  } out_item_t;

  // Result handed from the controller to the output register.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

  // Port controls of the pattern memory.
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DONE
  } psc_state_t;

endpackage

`default_nettype wire

@@ rtl/psc_pat_mem.sv @@
// Pattern table memory: one row per slot with byte lanes for characters and a length.
// Synchronous write with lane enables, registered read. Depends on psc_pkg.
`default_nettype none

module psc_pat_mem
  import psc_pkg::*;
#(
  parameter int DEPTH = 512,
  parameter int LANES = 8,
  parameter int AW    = 9,
  parameter int LEN_W = 4
) (
  input  wire logic                     clk,
  input  wire mem_ctl_t                 ctl,
  input  wire logic [AW-1:0]            waddr,
  input  wire logic [LANES-1:0]         lane_en,
  input  wire logic [LANES*SYM_W-1:0]   wchars,
  input  wire logic [LEN_W-1:0]         wlen,
  input  wire logic [AW-1:0]            raddr,
  output logic      [LANES*SYM_W-1:0]   rchars,
  output logic      [LEN_W-1:0]         rlen
);

  logic [LANES*SYM_W-1:0] chars_mem [DEPTH];
  logic [LEN_W-1:0]       len_mem   [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      for (int i = 0; i < LANES; i++) begin
        if (lane_en[i]) begin
          chars_mem[waddr][i*SYM_W +: SYM_W] <= wchars[i*SYM_W +: SYM_W];
        end
      end
      len_mem[waddr] <= wlen;
    end
    if (ctl.re) begin
      rchars <= chars_mem[raddr];
      rlen   <= len_mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/psc_ctrl.sv @@
// Controller: clearing pass, pattern writes, slot scan with compare and accumulate,
// and the recent design history. Depends on psc_pkg.
`default_nettype none

module psc_ctrl
  import psc_pkg::*;
#(
  parameter int NUM_PATTERNS = 512,
  parameter int MAX_PAT_LEN  = 8,
  parameter int AW           = 9,
  parameter int LEN_W        = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire in_item_t                       in_data,
  input  wire logic                           out_free,
  output res_t                                res,
  output mem_ctl_t                            mem_ctl,
  output logic      [AW-1:0]                  mem_waddr,
  output logic      [MAX_PAT_LEN-1:0]         mem_lane_en,
  output logic      [MAX_PAT_LEN*SYM_W-1:0]   mem_wchars,
  output logic      [LEN_W-1:0]               mem_wlen,
  output logic      [AW-1:0]                  mem_raddr,
  input  wire logic [MAX_PAT_LEN*SYM_W-1:0]   mem_rchars,
  input  wire logic [LEN_W-1:0]               mem_rlen
);

  psc_state_t state, state_next;

  logic [AW-1:0]      clr_cnt;
  logic [AW-1:0]      issue_cnt;
  logic               issuing;
  logic               rd_v;
  logic               m_valid;
  logic [COUNT_W-1:0] m_count;
  logic               m_flag;
  logic [COUNT_W-1:0] sum;
  logic               flag;
  logic               cur_last;

  logic [SYM_W-1:0]   recent_chars  [MAX_PAT_LEN];
  logic [COUNT_W-1:0] recent_counts [MAX_PAT_LEN+1];
  logic [MAX_PAT_LEN:0] recent_flags;
  logic [LEN_W-1:0]   pos;

  logic in_acc, pat_acc, des_acc, slot_ok;
  logic shift_counts, clear_design, res_valid;
  logic [31:0] plen_sat;
  logic [MAX_PAT_LEN:0] len_match;
  logic hit;
  logic [LEN_W-1:0] sel_idx;

  assign in_acc  = in_valid && !in_stall;
  assign pat_acc = in_acc && (in_data.func == FUNC_PATTERN);
  assign des_acc = in_acc && (in_data.func == FUNC_DESIGN);
  assign slot_ok = 32'(in_data.slot) < NUM_PATTERNS;
  assign plen_sat = (32'(in_data.pattern_len) > MAX_PAT_LEN) ? 32'(MAX_PAT_LEN)
                                                               : 32'(in_data.pattern_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_stall     = 1'b1;
    shift_counts = 1'b0;
    clear_design = 1'b0;
    res_valid    = 1'b0;
    case (state)
      S_CLEAR: begin
        if (clr_cnt == AW'(NUM_PATTERNS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && (in_data.func == FUNC_DESIGN)) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (!issuing && !rd_v && !m_valid) state_next = S_DONE;
      end
      S_DONE: begin
        if (!cur_last) begin
          shift_counts = 1'b1;
          state_next   = S_IDLE;
        end else if (out_free) begin
          res_valid    = 1'b1;
          clear_design = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // Memory write port: the clearing pass owns it after reset, pattern items afterwards.
  always_comb begin
    mem_ctl.re = issuing;
    mem_raddr  = issue_cnt;
    if (state == S_CLEAR) begin
      mem_ctl.we  = 1'b1;
      mem_waddr   = clr_cnt;
      mem_lane_en = '1;
      mem_wchars  = '0;
      mem_wlen    = '0;
    end else begin
      mem_ctl.we = pat_acc && slot_ok;
      mem_waddr  = AW'(in_data.slot);
      for (int i = 0; i < MAX_PAT_LEN; i++) begin
        mem_lane_en[i] = (32'(in_data.char_pos) == i);
      end
      mem_wchars = {MAX_PAT_LEN{in_data.symbol}};
      mem_wlen   = LEN_W'(plen_sat);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == S_CLEAR) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // Slot scan: one read issued per cycle, the registered read data back in the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing   <= 1'b0;
      issue_cnt <= '0;
      rd_v      <= 1'b0;
      m_valid   <= 1'b0;
    end else begin
      rd_v    <= issuing;
      m_valid <= rd_v;
      if (des_acc) begin
        issuing   <= 1'b1;
        issue_cnt <= '0;
      end else if (issuing) begin
        if (issue_cnt == AW'(NUM_PATTERNS - 1)) begin
          issuing <= 1'b0;
        end else begin
          issue_cnt <= issue_cnt + AW'(1);
        end
      end
    end
  end

  // A pattern of length L matches when its character j equals the design
  // character L-1-j places back from the newest one.
  always_comb begin
    len_match = '0;
    for (int l = 1; l <= MAX_PAT_LEN; l++) begin
      len_match[l] = 1'b1;
      for (int j = 0; j < l; j++) begin
        if (mem_rchars[j*SYM_W +: SYM_W] != recent_chars[l-1-j]) len_match[l] = 1'b0;
      end
    end
  end

  assign hit     = (mem_rlen != '0) && (mem_rlen <= pos) && len_match[mem_rlen];
  assign sel_idx = hit ? (mem_rlen - LEN_W'(1)) : '0;

  always_ff @(posedge clk) begin
    if (rd_v) begin
      m_count <= hit ? recent_counts[sel_idx] : '0;
      m_flag  <= hit && recent_flags[sel_idx];
    end
    if (des_acc) begin
      sum      <= '0;
      flag     <= 1'b0;
      cur_last <= in_data.last;
    end else if (m_valid) begin
      sum  <= sum + m_count;
      flag <= flag | m_flag;
    end
  end

  // Design history, newest first; the empty prefix starts with count one.
  always_ff @(posedge clk) begin
    if (rst || clear_design) begin
      for (int k = 0; k < MAX_PAT_LEN; k++) recent_chars[k] <= '0;
      for (int k = 1; k <= MAX_PAT_LEN; k++) recent_counts[k] <= '0;
      recent_counts[0] <= COUNT_W'(1);
      recent_flags     <= (MAX_PAT_LEN+1)'(1);
      pos              <= '0;
    end else begin
      if (des_acc) begin
        for (int k = MAX_PAT_LEN - 1; k > 0; k--) recent_chars[k] <= recent_chars[k-1];
        recent_chars[0] <= in_data.symbol;
        if (pos != LEN_W'(MAX_PAT_LEN)) pos <= pos + LEN_W'(1);
      end
      if (shift_counts) begin
        for (int k = MAX_PAT_LEN; k > 0; k--) recent_counts[k] <= recent_counts[k-1];
        recent_counts[0] <= sum;
        recent_flags     <= {recent_flags[MAX_PAT_LEN-1:0], flag};
      end
    end
  end

  always_comb begin
    res.valid         = res_valid;
    res.item.ways     = sum;
    res.item.possible = flag;
  end

  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!issuing && !rd_v && !m_valid))
    else $error("scan pipeline busy while idle");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(mem_ctl.we && mem_ctl.re))
    else $error("pattern memory written during a scan");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos <= LEN_W'(MAX_PAT_LEN))
    else $error("design position beyond the longest pattern");

  a_clear_after_result: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> (pos == '0 && recent_counts[0] == COUNT_W'(1)))
    else $error("design history not cleared after a result");

endmodule

`default_nettype wire

@@ rtl/pattern_segmentation_counter.sv @@
// Word-break counter: after a design transaction the next one is accepted only once the
// scan is through (one pattern-memory read per slot, read and sum pipeline, history
// update, return to idle); pattern transactions go back to back. A final character's
// result is valid once the scan is through, unless the output is still held.
// Reset is synchronous; a clearing pass then zeroes the pattern table while the input is
// stalled. Depends on psc_pkg, psc_pat_mem and psc_ctrl.
`default_nettype none

module pattern_segmentation_counter
  import psc_pkg::*;
#(
  parameter int NUM_PATTERNS = 512,
  parameter int MAX_PAT_LEN  = 8
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  // The slot address covers the table depth; the length field holds zero up to the
  // longest pattern.
  localparam int AW    = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
  localparam int LEN_W = $clog2(MAX_PAT_LEN + 1);

  mem_ctl_t                         mem_ctl;
  logic [AW-1:0]                    mem_waddr;
  logic [AW-1:0]                    mem_raddr;
  logic [MAX_PAT_LEN-1:0]           mem_lane_en;
  logic [MAX_PAT_LEN*SYM_W-1:0]     mem_wchars;
  logic [MAX_PAT_LEN*SYM_W-1:0]     mem_rchars;
  logic [LEN_W-1:0]                 mem_wlen;
  logic [LEN_W-1:0]                 mem_rlen;
  res_t                             res;
  logic                             out_free;

  // The pattern table: characters and length of every slot in one row.
  psc_pat_mem #(
    .DEPTH (NUM_PATTERNS),
    .LANES (MAX_PAT_LEN),
    .AW    (AW),
    .LEN_W (LEN_W)
  ) u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .waddr   (mem_waddr),
    .lane_en (mem_lane_en),
    .wchars  (mem_wchars),
    .wlen    (mem_wlen),
    .raddr   (mem_raddr),
    .rchars  (mem_rchars),
    .rlen    (mem_rlen)
  );

  // The controller scans every slot for each design character and sums the counts
  // of the prefixes where matching patterns start.
  psc_ctrl #(
    .NUM_PATTERNS (NUM_PATTERNS),
    .MAX_PAT_LEN  (MAX_PAT_LEN),
    .AW           (AW),
    .LEN_W        (LEN_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_free    (out_free),
    .res         (res),
    .mem_ctl     (mem_ctl),
    .mem_waddr   (mem_waddr),
    .mem_lane_en (mem_lane_en),
    .mem_wchars  (mem_wchars),
    .mem_wlen    (mem_wlen),
    .mem_raddr   (mem_raddr),
    .mem_rchars  (mem_rchars),
    .mem_rlen    (mem_rlen)
  );

  // The output register holds a finished result while the input side keeps taking
  // transactions. It is free when empty or when its result leaves at this edge.
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_data <= res.item;
    end
  end

  // A new result is only handed over when the output register can take it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (!out_valid || !out_stall))
    else $error("result overwrote a pending output transaction");

endmodule

`default_nettype wire
